// ----- hdl/go_back_n_window_endpoint_top_macros.svh -----
// Assertion macros for the go-back-n window endpoint.
`ifndef GO_BACK_N_WINDOW_ENDPOINT_TOP_MACROS_SVH
`define GO_BACK_N_WINDOW_ENDPOINT_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define GBN_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define GBN_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define GBN_ASSERT(label, prop, msg)
`define GBN_ASSERT_NEXT(label, pre, post, msg)
`endif

`endif

// ----- hdl/gbn_pkg.sv -----
// Types and constants shared by the go-back-n window endpoint.
`default_nettype none

package gbn_pkg;

  localparam int DATA_FIELD_W = 64;
  localparam int SEQ_FIELD_W  = 3;

  localparam logic [1:0] CMD_SEND      = 2'd0;
  localparam logic [1:0] CMD_FRAME     = 2'd1;
  localparam logic [1:0] CMD_CKSUM_ERR = 2'd2;
  localparam logic [1:0] CMD_TIMEOUT   = 2'd3;

  localparam logic [2:0] KIND_SENT      = 3'd0;
  localparam logic [2:0] KIND_DELIVERED = 3'd1;
  localparam logic [2:0] KIND_DISCARDED = 3'd2;
  localparam logic [2:0] KIND_NONE      = 3'd3;
  localparam logic [2:0] KIND_REFUSED   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACK,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]              cmd;
    logic [DATA_FIELD_W-1:0] payload;
    logic [SEQ_FIELD_W-1:0]  rx_seq;
    logic [SEQ_FIELD_W-1:0]  rx_ack;
  } cmd_item_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic [SEQ_FIELD_W-1:0]  tx_seq;
    logic [SEQ_FIELD_W-1:0]  tx_ack;
    logic [DATA_FIELD_W-1:0] data_out;
    logic [SEQ_FIELD_W-1:0]  outstanding;
    logic                    window_open;
    logic                    last;
  } res_item_t;

endpackage

`default_nettype wire

// ----- hdl/gbn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module gbn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/go_back_n_window_endpoint_top.sv -----
// Go-back-n sliding window endpoint: window control and outbound frame store.
// Send, checksum error, empty timeout: the result is registered at the transfer and offered in the next cycle.
// Frame arrival: acknowledged frames are released one at a time in the ack state, then the result is offered.
// Timeout: each retransmitted frame is read from the store, captured in the read state and offered in the out state.
// Synchronous reset clears pointers, count and sequencer; the frame store is not cleared.
`default_nettype none
`include "go_back_n_window_endpoint_top_macros.svh"

module go_back_n_window_endpoint_top
  import gbn_pkg::*;
#(
  parameter int MAX_SEQ_NUM   = 7,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cmd_valid,
  output logic           cmd_stall,
  input  wire cmd_item_t cmd_item,
  output logic           res_valid,
  input  wire logic      res_stall,
  output res_item_t      res_item
);

  localparam int SEQ_MOD = MAX_SEQ_NUM + 1;
  localparam int SW      = $clog2(SEQ_MOD);
  localparam int CW      = (SW > SEQ_FIELD_W) ? SW : SEQ_FIELD_W;

  function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] k);
    return (k == SW'(MAX_SEQ_NUM)) ? '0 : SW'(k + 1'b1);
  endfunction

  function automatic logic circ_between(input logic [CW-1:0] a, input logic [CW-1:0] b,
                                        input logic [CW-1:0] c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

  function automatic logic [SEQ_FIELD_W-1:0] fit_field(input logic [SW-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    return w[SEQ_FIELD_W-1:0];
  endfunction

  state_t state, state_next;

  logic [SW-1:0] next_to_send;
  logic [SW-1:0] oldest_unacked;
  logic [SW-1:0] expected_inbound;
  logic [SW-1:0] buffered_count;
  logic [SW-1:0] remaining;

  logic [SEQ_FIELD_W-1:0]   rack;
  logic [2:0]               res_kind;
  logic [SW-1:0]            res_seq;
  logic [SW-1:0]            res_ack;
  logic [PAYLOAD_WIDTH-1:0] res_data;
  logic                     res_last;

  logic                     ram_we;
  logic                     ram_rd_en;
  logic [SW-1:0]            ram_rd_addr;
  logic [PAYLOAD_WIDTH-1:0] ram_rd_data;
  logic [PAYLOAD_WIDTH-1:0] cmd_data;

  logic          cmd_xfer;
  logic          res_xfer;
  logic          window_full;
  logic          seq_match;
  logic          release_ok;
  logic [SW-1:0] ack_out;
  logic [SW:0]   win_span;
  logic          span_ok;

  assign cmd_xfer    = cmd_valid && !cmd_stall;
  assign res_xfer    = res_valid && !res_stall;
  assign cmd_data    = cmd_item.payload[PAYLOAD_WIDTH-1:0];
  assign window_full = buffered_count >= SW'(MAX_SEQ_NUM);
  assign seq_match   = CW'(cmd_item.rx_seq) == CW'(expected_inbound);
  assign ack_out     = (expected_inbound == '0) ? SW'(MAX_SEQ_NUM)
                                                : SW'(expected_inbound - 1'b1);
  assign release_ok  = (buffered_count != '0) &&
                       circ_between(CW'(oldest_unacked), CW'(rack), CW'(next_to_send));
  assign win_span    = (next_to_send >= oldest_unacked)
                     ? (SW+1)'(next_to_send - oldest_unacked)
                     : (SW+1)'((SW+1)'(next_to_send) + (SW+1)'(SEQ_MOD)
                               - (SW+1)'(oldest_unacked));
  assign span_ok     = (state != ST_IDLE) || (win_span == (SW+1)'(buffered_count));

  gbn_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (SEQ_MOD)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (next_to_send),
    .wr_data (cmd_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_xfer) begin
          case (cmd_item.cmd)
            CMD_FRAME:   state_next = ST_ACK;
            CMD_TIMEOUT: state_next = (buffered_count == '0) ? ST_OUT : ST_READ;
            default:     state_next = ST_OUT;
          endcase
        end
      end
      ST_ACK:  state_next = release_ok ? ST_ACK : ST_OUT;
      ST_READ: state_next = ST_OUT;
      ST_OUT: begin
        if (res_xfer) begin
          state_next = res_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_stall   = 1'b1;
    res_valid   = 1'b0;
    ram_we      = 1'b0;
    ram_rd_en   = 1'b0;
    ram_rd_addr = next_to_send;
    case (state)
      ST_IDLE: begin
        cmd_stall   = 1'b0;
        ram_we      = cmd_xfer && (cmd_item.cmd == CMD_SEND) && !window_full;
        ram_rd_en   = cmd_xfer && (cmd_item.cmd == CMD_TIMEOUT) && (buffered_count != '0);
        ram_rd_addr = oldest_unacked;
      end
      ST_OUT: begin
        res_valid = 1'b1;
        ram_rd_en = res_xfer && !res_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      next_to_send     <= '0;
      oldest_unacked   <= '0;
      expected_inbound <= '0;
      buffered_count   <= '0;
      remaining        <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (cmd_xfer) begin
            case (cmd_item.cmd)
              CMD_SEND: begin
                if (!window_full) begin
                  buffered_count <= SW'(buffered_count + 1'b1);
                  next_to_send   <= seq_inc(next_to_send);
                end
              end
              CMD_FRAME: begin
                if (seq_match) begin
                  expected_inbound <= seq_inc(expected_inbound);
                end
              end
              CMD_TIMEOUT: begin
                if (buffered_count != '0) begin
                  next_to_send <= oldest_unacked;
                  remaining    <= buffered_count;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ACK: begin
          if (release_ok) begin
            buffered_count <= SW'(buffered_count - 1'b1);
            oldest_unacked <= seq_inc(oldest_unacked);
          end
        end
        ST_READ: begin
          next_to_send <= seq_inc(next_to_send);
          remaining    <= SW'(remaining - 1'b1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (cmd_xfer) begin
          rack     <= cmd_item.rx_ack;
          res_last <= 1'b1;
          res_seq  <= '0;
          res_ack  <= '0;
          res_data <= '0;
          case (cmd_item.cmd)
            CMD_SEND: begin
              if (window_full) begin
                res_kind <= KIND_REFUSED;
              end else begin
                res_kind <= KIND_SENT;
                res_seq  <= next_to_send;
                res_ack  <= ack_out;
                res_data <= cmd_data;
              end
            end
            CMD_FRAME: begin
              res_kind <= seq_match ? KIND_DELIVERED : KIND_DISCARDED;
              res_data <= seq_match ? cmd_data : '0;
            end
            default: res_kind <= KIND_NONE;
          endcase
        end
      end
      ST_READ: begin
        res_kind <= KIND_SENT;
        res_seq  <= next_to_send;
        res_ack  <= ack_out;
        res_data <= ram_rd_data;
        res_last <= (remaining == SW'(1));
      end
      default: ;
    endcase
  end

  always_comb begin
    res_item.kind        = res_kind;
    res_item.tx_seq      = fit_field(res_seq);
    res_item.tx_ack      = fit_field(res_ack);
    res_item.data_out    = DATA_FIELD_W'(res_data);
    res_item.outstanding = fit_field(buffered_count);
    res_item.window_open = !window_full;
    res_item.last        = res_last;
  end

  `GBN_ASSERT(a_count_bound, buffered_count <= SW'(MAX_SEQ_NUM), "buffered count beyond window")
  `GBN_ASSERT(a_span_idle, span_ok, "window span mismatch")
  `GBN_ASSERT_NEXT(a_read_follows, ram_rd_en, state == ST_READ, "store read without capture")
  `GBN_ASSERT_NEXT(a_last_idle, res_xfer && res_last, state == ST_IDLE, "item did not end")

endmodule

`default_nettype wire

// ----- tb/sv/go_back_n_window_endpoint_top_test.sv -----
// Testbench for the go-back-n window endpoint: directed and random commands against a predictor.
`timescale 1ns / 1ps

module go_back_n_window_endpoint_top_test;
  import gbn_pkg::*;

  localparam logic [2:0] SEQ_MAX = 3'd7;

  class gbn_scoreboard;
    logic [DATA_FIELD_W-1:0] frame_store [8];
    logic [2:0] next_seq;
    logic [2:0] oldest_seq;
    logic [2:0] expected_seq;
    logic [2:0] in_flight;
    res_item_t  expected_q [$];
    int         errors;

    function new();
      next_seq = '0;
      oldest_seq = '0;
      expected_seq = '0;
      in_flight = '0;
      errors = 0;
    endfunction

    function bit seq_between(logic [2:0] a, logic [2:0] b, logic [2:0] c);
      return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

    function void push_result(logic [2:0] kind, logic [2:0] seq, logic [2:0] ack,
                              logic [DATA_FIELD_W-1:0] data, bit fin);
      res_item_t r;
      r.kind = kind;
      r.tx_seq = seq;
      r.tx_ack = ack;
      r.data_out = data;
      r.outstanding = in_flight;
      r.window_open = (in_flight < SEQ_MAX);
      r.last = fin;
      expected_q.push_back(r);
    endfunction

    function void note_command(cmd_item_t it);
      logic [2:0] kind;
      logic [DATA_FIELD_W-1:0] dout;
      logic [2:0] seq;
      int n;
      case (it.cmd)
        CMD_SEND: begin
          if (in_flight >= SEQ_MAX) begin
            push_result(KIND_REFUSED, '0, '0, '0, 1'b1);
          end else begin
            seq = next_seq;
            frame_store[seq] = it.payload;
            in_flight++;
            next_seq = seq + 3'd1;
            push_result(KIND_SENT, seq, expected_seq - 3'd1, it.payload, 1'b1);
          end
        end
        CMD_FRAME: begin
          dout = '0;
          if (it.rx_seq == expected_seq) begin
            kind = KIND_DELIVERED;
            dout = it.payload;
            expected_seq++;
          end else begin
            kind = KIND_DISCARDED;
          end
          for (int g = 0; g <= int'(SEQ_MAX) && in_flight > 0 &&
               seq_between(oldest_seq, it.rx_ack, next_seq); g++) begin
            in_flight--;
            oldest_seq++;
          end
          push_result(kind, '0, '0, dout, 1'b1);
        end
        CMD_CKSUM_ERR: push_result(KIND_NONE, '0, '0, '0, 1'b1);
        default: begin
          if (in_flight == 0) begin
            push_result(KIND_NONE, '0, '0, '0, 1'b1);
          end else begin
            n = int'(in_flight);
            next_seq = oldest_seq;
            for (int i = 0; i < n; i++) begin
              seq = next_seq;
              push_result(KIND_SENT, seq, expected_seq - 3'd1, frame_store[seq], i + 1 == n);
              next_seq = seq + 3'd1;
            end
          end
        end
      endcase
    endfunction

    function void check_field(string name, logic [DATA_FIELD_W-1:0] want,
                              logic [DATA_FIELD_W-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with nothing expected: %p", got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("kind", DATA_FIELD_W'(want.kind), DATA_FIELD_W'(got.kind));
      check_field("tx_seq", DATA_FIELD_W'(want.tx_seq), DATA_FIELD_W'(got.tx_seq));
      check_field("tx_ack", DATA_FIELD_W'(want.tx_ack), DATA_FIELD_W'(got.tx_ack));
      check_field("data_out", want.data_out, got.data_out);
      check_field("outstanding", DATA_FIELD_W'(want.outstanding),
                  DATA_FIELD_W'(got.outstanding));
      check_field("window_open", DATA_FIELD_W'(want.window_open),
                  DATA_FIELD_W'(got.window_open));
      check_field("last", DATA_FIELD_W'(want.last), DATA_FIELD_W'(got.last));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      cmd_valid;
  logic      cmd_stall;
  cmd_item_t cmd_item;
  logic      res_valid;
  logic      res_stall;
  res_item_t res_item;

  gbn_scoreboard sb;
  int            send_idle_pct;

  go_back_n_window_endpoint_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd_item (cmd_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("go_back_n_window_endpoint_top_test: done, errors");
    $finish;
  end

  function automatic cmd_item_t make_cmd(logic [1:0] cmd, logic [DATA_FIELD_W-1:0] data,
                                         logic [2:0] seq, logic [2:0] ack);
    cmd_item_t it;
    it.cmd = cmd;
    it.payload = data;
    it.rx_seq = seq;
    it.rx_ack = ack;
    return it;
  endfunction

  function automatic logic [DATA_FIELD_W-1:0] rand_data();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic drive_command(cmd_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item <= it;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sb.note_command(it);
    @(negedge clk);
  endtask

  function automatic cmd_item_t random_command();
    logic [2:0] seq;
    logic [2:0] ack;
    int roll;
    roll = $urandom_range(0, 99);
    seq = 3'($urandom_range(0, 7));
    ack = 3'($urandom_range(0, 7));
    if (roll < 45) return make_cmd(CMD_SEND, rand_data(), seq, ack);
    if (roll < 80) begin
      if ($urandom_range(0, 99) < 70) seq = sb.expected_seq;
      if (sb.in_flight > 0 && $urandom_range(0, 99) < 70)
        ack = sb.oldest_seq + 3'($urandom_range(0, sb.in_flight - 1));
      return make_cmd(CMD_FRAME, rand_data(), seq, ack);
    end
    if (roll < 88) return make_cmd(CMD_CKSUM_ERR, rand_data(), seq, ack);
    return make_cmd(CMD_TIMEOUT, rand_data(), seq, ack);
  endfunction

  // receiver side: random stall, one long hold-off, one stretch with no stall
  initial begin
    int cyc;
    cyc = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 300 && cyc < 380) res_stall <= 1'b1;
      else if (cyc >= 800 && cyc < 1100) res_stall <= 1'b0;
      else res_stall <= ($urandom_range(0, 99) < 26);
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) sb.check_result(res_item);
  end

  initial begin
    cmd_item_t directed [$];
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_item = '0;
    send_idle_pct = 26;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed.push_back(make_cmd(CMD_CKSUM_ERR, '1, 3'd7, 3'd7));
    directed.push_back(make_cmd(CMD_TIMEOUT, '0, 3'd0, 3'd0));
    directed.push_back(make_cmd(CMD_FRAME, '1, 3'd0, 3'd0));
    directed.push_back(make_cmd(CMD_FRAME, '0, 3'd0, 3'd7));
    directed.push_back(make_cmd(CMD_SEND, '0, 3'd0, 3'd0));
    directed.push_back(make_cmd(CMD_SEND, '1, 3'd7, 3'd7));
    directed.push_back(make_cmd(CMD_SEND, 64'haaaa_aaaa_aaaa_aaaa, 3'd0, 3'd0));
    directed.push_back(make_cmd(CMD_SEND, 64'h5555_5555_5555_5555, 3'd0, 3'd0));
    directed.push_back(make_cmd(CMD_SEND, 64'h8000_0000_0000_0001, 3'd0, 3'd0));
    directed.push_back(make_cmd(CMD_SEND, {$urandom(), $urandom()}, 3'd0, 3'd0));
    directed.push_back(make_cmd(CMD_SEND, {$urandom(), $urandom()}, 3'd0, 3'd0));
    // window full
    directed.push_back(make_cmd(CMD_SEND, '1, 3'd0, 3'd0));
    directed.push_back(make_cmd(CMD_TIMEOUT, '0, 3'd0, 3'd0));
    // ack equal to next sequence is outside the window
    directed.push_back(make_cmd(CMD_FRAME, {$urandom(), $urandom()}, 3'd1, 3'd7));
    directed.push_back(make_cmd(CMD_FRAME, {$urandom(), $urandom()}, 3'd2, 3'd2));
    directed.push_back(make_cmd(CMD_SEND, {$urandom(), $urandom()}, 3'd0, 3'd0));
    directed.push_back(make_cmd(CMD_FRAME, {$urandom(), $urandom()}, 3'd5, 3'd0));
    directed.push_back(make_cmd(CMD_TIMEOUT, '1, 3'd7, 3'd7));
    // ack across the wrap releases everything
    directed.push_back(make_cmd(CMD_FRAME, {$urandom(), $urandom()}, 3'd3, 3'd7));
    directed.push_back(make_cmd(CMD_TIMEOUT, '0, 3'd0, 3'd0));
    directed.push_back(make_cmd(CMD_SEND, {$urandom(), $urandom()}, 3'd0, 3'd0));

    foreach (directed[i]) drive_command(directed[i]);

    for (int i = 0; i < 330; i++) begin
      send_idle_pct = (i >= 150 && i < 230) ? 0 : 26;
      drive_command(random_command());
    end
    cmd_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("go_back_n_window_endpoint_top_test: done, clean");
    else
      $display("go_back_n_window_endpoint_top_test: done, errors");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/gbn_pkg.sv
hdl/gbn_ram.sv
hdl/go_back_n_window_endpoint_top.sv
tb/sv/go_back_n_window_endpoint_top_test.sv
